// ===== rtl/fhsc_pkg.sv =====
// shared types and constants of the floppy head seek controller
package fhsc_pkg;

   // command codes on the request channel
   typedef enum logic [2:0] {
      OP_SEEK        = 3'd0,
      OP_RECAL_START = 3'd1,
      OP_RECAL_PROBE = 3'd2,
      OP_CHANGE_STEP = 3'd3,
      OP_PRECOMP     = 3'd4
   } op_type;

   // drive action codes on the response channel
   typedef enum logic [2:0] {
      ACT_WAIT    = 3'd0,
      ACT_STEP    = 3'd1,
      ACT_SELECT  = 3'd2,
      ACT_DONE    = 3'd3,
      ACT_TIMEOUT = 3'd4
   } action_type;

   // configuration register indexes
   localparam logic [1:0] CSR_CYLINDER_COUNT = 2'd0;
   localparam logic [1:0] CSR_LIMIT_NONE     = 2'd1;
   localparam logic [1:0] CSR_LIMIT_SMALL    = 2'd2;
   localparam logic [1:0] CSR_LIMIT_MEDIUM   = 2'd3;

   // timing in microseconds
   localparam logic [15:0] WAIT_REVERSE_US = 16'd18000;
   localparam logic [15:0] WAIT_SAME_US    = 16'd2000;
   localparam logic [15:0] SETTLE_STEP_US  = 16'd15000;
   localparam logic [15:0] SETTLE_HEAD_US  = 16'd100;
   localparam logic [15:0] RECAL_STEP_US   = 16'd3000;
   localparam logic [15:0] RECAL_START_US  = 16'd18000;
   localparam logic [15:0] TRACK0_SETTLE_US = 16'd15000;

   localparam logic [1:0] HEAD_UNKNOWN = 2'd3;
   localparam int unsigned MAX_RESULTS = 5;

   // one queued response entry, cylinder is shared per command
   typedef struct packed {
      action_type  action;
      logic        step_inward;
      logic [15:0] amount;
      logic [1:0]  precomp_class;
   } entry_type;

endpackage

// ===== rtl/floppy_head_seek_controller_unit.sv =====
// floppy head positioner: command decode, tracked state and response queue
//
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  req_tdata[15:0]
// rsp      out  rsp_tvalid/rsp_tready  rsp_tdata[31:0], rsp_tlast
// csr      in   csr_we                 csr_addr[1:0], csr_wdata[6:0]
//
// a command is decoded in the cycle it is accepted and its whole response list
// (one to five transactions) is loaded into a five-entry queue register
// the queue drains one transaction per cycle while rsp_tready is high, and the next
// command is taken in the cycle the last one leaves
// a stalled rsp side holds the queue and blocks req; unused op codes give nothing
// synchronous reset returns to unknown cylinder and head, registers to defaults
module floppy_head_seek_controller_unit
   import fhsc_pkg::*;
#(
   parameter int RECAL_STEP_LIMIT = 80
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // op[2:0], target_cylinder[9:3], target_head[10], at_track0[11],
   // write_access[12], zero[15:13]
   input  logic [15:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // action[2:0], step_inward[3], amount[19:4], current_cylinder[27:20],
   // precomp_class[29:28], zero[31:30]
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [6:0]  csr_wdata
);

   localparam logic [6:0] RECAL_LIMIT = 7'(RECAL_STEP_LIMIT);

   // configuration registers
   logic [6:0] cyl_count_ff, lim_none_ff, lim_small_ff, lim_medium_ff;

   // tracked drive state
   logic signed [7:0] head_cyl_ff, head_cyl_in;
   logic [1:0]        head_sel_ff, head_sel_in;
   logic              last_inward_ff, last_inward_in;
   logic              chg_inward_ff, chg_inward_in;
   logic [6:0]        recal_cnt_ff, recal_cnt_in;

   // response queue
   entry_type         queue_ff [MAX_RESULTS];
   entry_type         queue_in [MAX_RESULTS];
   logic [2:0]        count_ff, count_in;
   logic signed [7:0] out_cyl_ff;

   // request fields
   op_type     op;
   logic [6:0] target_cyl;
   logic       target_head;
   logic       at_track0;
   logic       write_access;

   logic req_fire, rsp_fire;

   // shared seek path
   logic signed [8:0] seek_target;
   logic [1:0]        seek_head;
   logic signed [8:0] diff;
   logic              seek_inward;
   logic [15:0]       seek_steps;
   logic              seek_move;
   logic              seek_change;

   // change-reset target
   logic signed [8:0] chg_try;
   logic signed [8:0] chg_target;
   logic              chg_dir_set;
   logic              chg_dir_val;
   logic signed [8:0] cyl_max;

   // precomp class
   logic signed [8:0] head_cyl_ext;
   logic [1:0]        pc_class;
   logic [6:0]        recal_inc;

   assign op           = op_type'(req_tdata[2:0]);
   assign target_cyl   = req_tdata[9:3];
   assign target_head  = req_tdata[10];
   assign at_track0    = req_tdata[11];
   assign write_access = req_tdata[12];

   // handshakes
   assign rsp_tvalid = (count_ff != 3'd0);
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign req_tready = (count_ff == 3'd0) || (count_ff == 3'd1 && rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   assign rsp_tdata = {2'b00, queue_ff[0].precomp_class, out_cyl_ff,
                       queue_ff[0].amount, queue_ff[0].step_inward,
                       queue_ff[0].action};
   assign rsp_tlast = (count_ff == 3'd1);

   // change-reset: step around the current cylinder, turning at the edges
   assign head_cyl_ext = 9'(head_cyl_ff);
   assign cyl_max      = $signed({2'b00, cyl_count_ff}) - 9'sd1;
   always_comb begin
      chg_try     = chg_inward_ff ? head_cyl_ext + 9'sd1 : head_cyl_ext - 9'sd1;
      chg_target  = chg_try;
      chg_dir_set = 1'b0;
      chg_dir_val = 1'b0;
      if (chg_try > cyl_max) begin
         chg_target  = head_cyl_ext - 9'sd1;
         chg_dir_set = 1'b1;
         chg_dir_val = 1'b0;
      end else if (chg_try < 9'sd0) begin
         chg_target  = 9'sd1;
         chg_dir_set = 1'b1;
         chg_dir_val = 1'b1;
      end
      if (chg_target < 9'sd0) begin
         chg_target = 9'sd0;
      end
   end

   // seek distance and direction
   always_comb begin
      if (op == OP_CHANGE_STEP) begin
         seek_target = chg_target;
         seek_head   = head_sel_ff;
      end else begin
         seek_target = $signed({2'b00, target_cyl});
         seek_head   = {1'b0, target_head};
      end
      diff        = seek_target - head_cyl_ext;
      seek_inward = (diff >= 9'sd0);
      seek_steps  = seek_inward ? 16'(diff) : 16'(-diff);
      seek_move   = (diff != 9'sd0);
      seek_change = (seek_head != head_sel_ff);
   end

   // precomp class from the limits
   always_comb begin
      pc_class = 2'd0;
      if (write_access) begin
         priority if (head_cyl_ext <= $signed({2'b00, lim_none_ff})) pc_class = 2'd0;
         else if (head_cyl_ext <= $signed({2'b00, lim_small_ff}))    pc_class = 2'd1;
         else if (head_cyl_ext <= $signed({2'b00, lim_medium_ff}))   pc_class = 2'd2;
         else                                                        pc_class = 2'd3;
      end
   end

   assign recal_inc = (recal_cnt_ff != 7'd127) ? recal_cnt_ff + 7'd1 : recal_cnt_ff;

   // response list and next state for the accepted command
   always_comb begin
      logic [2:0] k;
      k = 3'd0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         queue_in[i] = '{action: ACT_WAIT, step_inward: 1'b0, amount: 16'd0,
                         precomp_class: 2'd0};
      end
      head_cyl_in    = head_cyl_ff;
      head_sel_in    = head_sel_ff;
      last_inward_in = last_inward_ff;
      chg_inward_in  = chg_inward_ff;
      recal_cnt_in   = recal_cnt_ff;

      unique case (op)
         OP_SEEK, OP_CHANGE_STEP: begin
            if (op == OP_SEEK && !seek_move && !seek_change) begin
               queue_in[k].action = ACT_DONE;
               k = k + 3'd1;
            end else begin
               // direction wait
               queue_in[k].action = ACT_WAIT;
               queue_in[k].amount = (seek_move && seek_inward != last_inward_ff) ?
                                    WAIT_REVERSE_US : WAIT_SAME_US;
               k = k + 3'd1;
               if (seek_move) begin
                  queue_in[k].action      = ACT_STEP;
                  queue_in[k].step_inward = seek_inward;
                  queue_in[k].amount      = seek_steps;
                  k = k + 3'd1;
                  head_cyl_in    = 8'(seek_target);
                  last_inward_in = seek_inward;
               end
               if (seek_change) begin
                  queue_in[k].action = ACT_SELECT;
                  queue_in[k].amount = 16'(seek_head);
                  k = k + 3'd1;
                  head_sel_in = seek_head;
               end
               // settle wait
               if (seek_move || seek_change) begin
                  queue_in[k].action = ACT_WAIT;
                  queue_in[k].amount = seek_move ? SETTLE_STEP_US : SETTLE_HEAD_US;
                  k = k + 3'd1;
               end
               queue_in[k].action = ACT_DONE;
               k = k + 3'd1;
               if (op == OP_CHANGE_STEP) begin
                  chg_inward_in = (chg_dir_set ? chg_dir_val : chg_inward_ff) ^ 1'b1;
               end
            end
         end
         OP_RECAL_START: begin
            queue_in[0].action = ACT_WAIT;
            queue_in[0].amount = RECAL_START_US;
            k = 3'd1;
            recal_cnt_in = 7'd0;
            head_cyl_in  = -8'sd1;
            head_sel_in  = HEAD_UNKNOWN;
         end
         OP_RECAL_PROBE: begin
            if (at_track0) begin
               queue_in[0].action = ACT_SELECT;
               queue_in[1].action = ACT_WAIT;
               queue_in[1].amount = TRACK0_SETTLE_US;
               queue_in[2].action = ACT_DONE;
               k = 3'd3;
               head_cyl_in    = 8'sd0;
               head_sel_in    = 2'd0;
               last_inward_in = 1'b0;
               recal_cnt_in   = 7'd0;
            end else begin
               queue_in[0].action = ACT_STEP;
               queue_in[0].amount = 16'd1;
               recal_cnt_in = recal_inc;
               if (recal_inc > RECAL_LIMIT) begin
                  queue_in[1].action = ACT_TIMEOUT;
               end else begin
                  queue_in[1].action = ACT_WAIT;
                  queue_in[1].amount = RECAL_STEP_US;
               end
               k = 3'd2;
            end
         end
         OP_PRECOMP: begin
            queue_in[0].action        = ACT_DONE;
            queue_in[0].precomp_class = pc_class;
            k = 3'd1;
         end
         default: begin
            k = 3'd0;
         end
      endcase
      count_in = k;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cyl_count_ff  <= 7'd80;
         lim_none_ff   <= 7'd127;
         lim_small_ff  <= 7'd127;
         lim_medium_ff <= 7'd127;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_CYLINDER_COUNT: cyl_count_ff  <= csr_wdata;
            CSR_LIMIT_NONE:     lim_none_ff   <= csr_wdata;
            CSR_LIMIT_SMALL:    lim_small_ff  <= csr_wdata;
            CSR_LIMIT_MEDIUM:   lim_medium_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // tracked state and queue count
   always_ff @(posedge clock) begin
      if (reset) begin
         head_cyl_ff    <= -8'sd1;
         head_sel_ff    <= HEAD_UNKNOWN;
         last_inward_ff <= 1'b0;
         chg_inward_ff  <= 1'b0;
         recal_cnt_ff   <= 7'd0;
         count_ff       <= 3'd0;
      end else if (req_fire) begin
         head_cyl_ff    <= head_cyl_in;
         head_sel_ff    <= head_sel_in;
         last_inward_ff <= last_inward_in;
         chg_inward_ff  <= chg_inward_in;
         recal_cnt_ff   <= recal_cnt_in;
         count_ff       <= count_in;
      end else if (rsp_fire) begin
         count_ff <= count_ff - 3'd1;
      end
   end

   // queue payload: load a whole list or shift one transaction out
   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            queue_ff[i] <= queue_in[i];
         end
         out_cyl_ff <= head_cyl_in;
      end else if (rsp_fire) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            queue_ff[i] <= queue_ff[i + 1];
         end
      end
   end

endmodule
